@@ design/arp_reply_cache_with_aging_top_macros.svh @@
// Assertion macros for the ARP reply cache.
`ifndef ARP_REPLY_CACHE_WITH_AGING_TOP_MACROS_SVH
`define ARP_REPLY_CACHE_WITH_AGING_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked outside reset.
`define ARPC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define ARPC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARPC_ASSERT(name, prop, msg)
`define ARPC_ASSERT_RST(name, prop, msg)
`endif
`endif

@@ design/arpc_pkg.sv @@
// Types and constants shared by the ARP reply cache modules.
package arpc_pkg;

  localparam logic [1:0]  MODE_FRAME = 2'd0;
  localparam logic [1:0]  MODE_QUERY = 2'd1;
  localparam logic [1:0]  MODE_TICK  = 2'd2;

  localparam logic [15:0] OPC_REPLY     = 16'd2;
  localparam logic [23:0] AGING_RESET   = 24'd300000;
  localparam logic [10:0] MIN_LEN_RESET = 11'd42;
  localparam logic [6:0]  EXP_MAX       = 7'd127;

  localparam logic        CFG_AGING  = 1'b0;
  localparam logic        CFG_MINLEN = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_LEARNED   = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_MALFORMED = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LEARN,
    OP_QUERY,
    OP_TICK
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  // Token passed from cell to cell.
  typedef struct packed {
    logic        vld;
    op_t         op;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        hit;
    logic        free_found;
    logic [6:0]  expired;
  } carry_t;

  // Broadcast write of a new entry.
  typedef struct packed {
    logic        en;
    logic [31:0] ip;
    logic [47:0] mac;
  } fill_t;

endpackage

@@ design/arpc_cell.sv @@
// One cache entry with its compare, aging and token stage.
module arpc_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [23:0]      aging,
  input  arpc_pkg::fill_t  fill,
  input  logic [IW-1:0]    fill_idx,
  input  arpc_pkg::carry_t carry_in,
  input  logic [IW-1:0]    fidx_in,
  output arpc_pkg::carry_t carry_out,
  output logic [IW-1:0]    fidx_out
);
  import arpc_pkg::*;

  logic        valid_r, valid_nxt;
  logic [31:0] ip_r, ip_nxt;
  logic [47:0] mac_r, mac_nxt;
  logic [23:0] age_r, age_nxt;
  carry_t      carry_r, carry_nxt;
  logic [IW-1:0] fidx_r, fidx_nxt;
  logic        match;

  assign match = valid_r && (ip_r == carry_in.ip);

  always_comb begin
    valid_nxt = valid_r;
    ip_nxt    = ip_r;
    mac_nxt   = mac_r;
    age_nxt   = age_r;
    carry_nxt = carry_in;
    fidx_nxt  = fidx_in;
    if (carry_in.vld) begin
      unique case (carry_in.op)
        OP_LEARN: begin
          if (match && !carry_in.hit) begin
            mac_nxt       = carry_in.mac;
            age_nxt       = aging;
            carry_nxt.hit = 1'b1;
          end else if (!valid_r && !carry_in.free_found) begin
            carry_nxt.free_found = 1'b1;
            fidx_nxt             = IW'(IDX);
          end
        end
        OP_QUERY: begin
          if (match && !carry_in.hit) begin
            carry_nxt.hit = 1'b1;
            carry_nxt.mac = mac_r;
          end
        end
        OP_TICK: begin
          if (valid_r) begin
            if (age_r <= 24'd1) begin
              valid_nxt = 1'b0;
              age_nxt   = '0;
              if (carry_in.expired < EXP_MAX) begin
                carry_nxt.expired = carry_in.expired + 7'd1;
              end
            end else begin
              age_nxt = age_r - 24'd1;
            end
          end
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
    if (fill.en && (fill_idx == IW'(IDX))) begin
      valid_nxt = 1'b1;
      ip_nxt    = fill.ip;
      mac_nxt   = fill.mac;
      age_nxt   = aging;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ip_r  <= ip_nxt;
    mac_r <= mac_nxt;
    age_r <= age_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r.vld <= 1'b0;
    end else begin
      carry_r.vld <= carry_nxt.vld;
    end
    carry_r.op         <= carry_nxt.op;
    carry_r.ip         <= carry_nxt.ip;
    carry_r.mac        <= carry_nxt.mac;
    carry_r.hit        <= carry_nxt.hit;
    carry_r.free_found <= carry_nxt.free_found;
    carry_r.expired    <= carry_nxt.expired;
    fidx_r             <= fidx_nxt;
  end

  assign carry_out = carry_r;
  assign fidx_out  = fidx_r;

endmodule

@@ design/arp_reply_cache_with_aging_top.sv @@
// ARP reply cache with aging: cell chain, control and result register.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_valid / in_ready  | mode, frame_length, opcode, ip_addr, src_mac
//  out_    | out | out_valid / out_ready| status, found_mac, expired_count
//  cfg_    | in  | cfg_we               | cfg_index, cfg_wdata
//
// Each beat passes once through the chain of ENTRIES cells, one cell per cycle.
// A result is captured in the result register as the token leaves the chain; the next
// beat is taken once that result has moved into the output register.
// One item goes through four steps in order: inject, chain, capture, load.
// A stalled output holds the block in drain; the chain itself never stalls.
// Reset is synchronous and clears all valid bits.
module arp_reply_cache_with_aging_top #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [10:0] in_frame_length,
  input  logic [15:0] in_opcode,
  input  logic [31:0] in_ip_addr,
  input  logic [47:0] in_src_mac,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [47:0] out_found_mac,
  output logic [6:0]  out_expired_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata
);
  import arpc_pkg::*;

  `include "arp_reply_cache_with_aging_top_macros.svh"

  localparam int IW = $clog2(ENTRIES);

  state_t      state_r, state_nxt;
  logic [23:0] aging_r;
  logic [10:0] min_len_r;
  carry_t      head_r, head_nxt;
  status_t     pend_st_r, pend_st_nxt;
  status_t     res_st_r, res_st_nxt;
  logic [47:0] res_mac_r, res_mac_nxt;
  logic [6:0]  res_exp_r, res_exp_nxt;
  logic        out_valid_r, out_valid_nxt;
  status_t     out_st_r;
  logic [47:0] out_mac_r;
  logic [6:0]  out_exp_r;
  logic        accept, load_out;
  fill_t       fill;
  carry_t      chain [ENTRIES+1];
  logic [IW-1:0] fidx [ENTRIES+1];
  carry_t      tail;

  assign chain[0] = head_r;
  assign fidx[0]  = '0;
  assign tail     = chain[ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arpc_cell #(
      .IDX(g),
      .IW (IW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .aging    (aging_r),
      .fill     (fill),
      .fill_idx (fidx[ENTRIES]),
      .carry_in (chain[g]),
      .fidx_in  (fidx[g]),
      .carry_out(chain[g+1]),
      .fidx_out (fidx[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aging_r   <= AGING_RESET;
      min_len_r <= MIN_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AGING:  aging_r   <= cfg_wdata;
        CFG_MINLEN: min_len_r <= cfg_wdata[10:0];
        default: begin
        end
      endcase
    end
  end

  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == S_DRAIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    head_nxt      = head_r;
    head_nxt.vld  = 1'b0;
    pend_st_nxt   = pend_st_r;
    res_st_nxt    = res_st_r;
    res_mac_nxt   = res_mac_r;
    res_exp_nxt   = res_exp_r;
    out_valid_nxt = out_valid_r;
    fill.en       = 1'b0;
    fill.ip       = tail.ip;
    fill.mac      = tail.mac;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          head_nxt.vld        = 1'b1;
          head_nxt.ip         = in_ip_addr;
          head_nxt.mac        = in_src_mac;
          head_nxt.hit        = 1'b0;
          head_nxt.free_found = 1'b0;
          head_nxt.expired    = '0;
          head_nxt.op         = OP_NONE;
          pend_st_nxt         = ST_IGNORED;
          unique case (in_mode)
            MODE_FRAME: begin
              if (in_frame_length < min_len_r) begin
                pend_st_nxt = ST_MALFORMED;
              end else if (in_opcode == OPC_REPLY) begin
                head_nxt.op = OP_LEARN;
              end
            end
            MODE_QUERY: head_nxt.op = OP_QUERY;
            MODE_TICK:  head_nxt.op = OP_TICK;
            default: begin
            end
          endcase
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (tail.vld) begin
          res_st_nxt  = pend_st_r;
          res_mac_nxt = '0;
          res_exp_nxt = '0;
          unique case (tail.op)
            OP_LEARN: begin
              if (tail.hit) begin
                res_st_nxt = ST_LEARNED;
              end else if (tail.free_found) begin
                res_st_nxt = ST_LEARNED;
                fill.en    = 1'b1;
              end else begin
                res_st_nxt = ST_FULL;
              end
            end
            OP_QUERY: begin
              if (tail.hit) begin
                res_st_nxt  = ST_HIT;
                res_mac_nxt = tail.mac;
              end else begin
                res_st_nxt = ST_MISS;
              end
            end
            OP_TICK: begin
              res_st_nxt  = ST_IGNORED;
              res_exp_nxt = tail.expired;
            end
            OP_NONE: begin
            end
            default: begin
            end
          endcase
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else begin
      head_r.vld <= head_nxt.vld;
    end
    head_r.op         <= head_nxt.op;
    head_r.ip         <= head_nxt.ip;
    head_r.mac        <= head_nxt.mac;
    head_r.hit        <= head_nxt.hit;
    head_r.free_found <= head_nxt.free_found;
    head_r.expired    <= head_nxt.expired;
    pend_st_r         <= pend_st_nxt;
    res_st_r          <= res_st_nxt;
    res_mac_r         <= res_mac_nxt;
    res_exp_r         <= res_exp_nxt;
    if (load_out) begin
      out_st_r  <= res_st_r;
      out_mac_r <= res_mac_r;
      out_exp_r <= res_exp_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_st_r;
  assign out_found_mac     = out_mac_r;
  assign out_expired_count = out_exp_r;

  `ARPC_ASSERT(a_single_token, head_r.vld |=> !head_r.vld, "second token entered chain")
  `ARPC_ASSERT(a_tail_in_run, tail.vld |-> (state_r == S_RUN), "token left chain outside run")
  `ARPC_ASSERT(a_accept_runs, accept |=> (state_r == S_RUN && head_r.vld), "beat not injected")
  `ARPC_ASSERT(a_out_from_drain, $rose(out_valid_r) |-> $past(state_r == S_DRAIN), "result without drain")
  `ARPC_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "reset not idle")

endmodule
